>>> rtl/tlv_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// TLV stream decoder assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TLV_STREAM_DECODER_ASSERT_SVH
`define TLV_STREAM_DECODER_ASSERT_SVH

// cond holds at every clock edge
`define TLV_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tlv assertion failed");

// ante at one edge implies cons at the next edge
`define TLV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlv assertion failed");

`endif

>>> rtl/tlv_pkg.sv
// ----------------------------------------------------------------------------
// TLV decoder package
// Parse phases, result kinds, the front-to-back command and queue sizing.
// ----------------------------------------------------------------------------
package tlv_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] MIN_ITEM_BYTES = 8'd3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_LEN   = 3'd2,
    PH_EXT   = 3'd3,
    PH_VALUE = 3'd4,
    PH_DROP  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    K_HEADER = 2'd0,
    K_VALUE  = 2'd1,
    K_END    = 2'd2,
    K_ERROR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] item_type;
    logic [6:0]  item_length;
    logic [7:0]  value_byte;
    logic [6:0]  value_offset;
    logic        with_end;
  } cmd_t;

endpackage

>>> rtl/tlv_front.sv
// ----------------------------------------------------------------------------
// TLV decoder front end
// Accepts buffer bytes, tracks the item parse and issues one command per
// byte that causes results.
// ----------------------------------------------------------------------------
module tlv_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         buffer_start,
  input  logic [7:0]   buffer_length,
  output logic         push,
  output tlv_pkg::cmd_t push_cmd
);
  import tlv_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  type_low, type_low_next;
  logic [6:0]  pending_length, pending_length_next;
  logic [6:0]  value_count, value_count_next;

  phase_t      cur_phase;
  logic [7:0]  cur_left;
  logic [7:0]  after;
  logic        do_finish;
  logic [15:0] fin_type;
  logic [6:0]  fin_len;
  logic [6:0]  count_inc;
  logic        emit;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bytes_left     <= '0;
      type_low       <= '0;
      pending_length <= '0;
      value_count    <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      type_low       <= type_low_next;
      pending_length <= pending_length_next;
      value_count    <= value_count_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    type_low_next       = type_low;
    pending_length_next = pending_length;
    value_count_next    = value_count;
    cur_phase           = phase;
    cur_left            = bytes_left;
    do_finish           = 1'b0;
    fin_type            = '0;
    fin_len             = '0;
    emit                = 1'b0;
    cmd                 = '0;
    count_inc           = value_count + 7'd1;

    if (buffer_start) begin
      value_count_next = '0;
      cur_left         = buffer_length;
      cur_phase        = PH_TYPE;
      if (buffer_length == 8'd0) begin
        cur_phase = PH_IDLE;
      end
    end
    after = cur_left - 8'd1;

    if (cur_phase == PH_IDLE || cur_left == 8'd0) begin
      phase_next      = PH_IDLE;
      bytes_left_next = cur_left;
    end else begin
      bytes_left_next = after;
      phase_next      = cur_phase;
      case (cur_phase)
        PH_TYPE: begin
          if (cur_left < MIN_ITEM_BYTES) begin
            emit       = 1'b1;
            cmd.kind   = K_ERROR;
            phase_next = (after == 8'd0) ? PH_IDLE : PH_DROP;
          end else begin
            type_low_next = data_byte;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          pending_length_next = data_byte[6:0];
          if (data_byte[7]) begin
            phase_next = PH_EXT;
          end else begin
            do_finish = 1'b1;
            fin_type  = {8'd0, type_low};
            fin_len   = data_byte[6:0];
          end
        end
        PH_EXT: begin
          do_finish = 1'b1;
          fin_type  = {data_byte, type_low};
          fin_len   = pending_length;
        end
        PH_VALUE: begin
          emit             = 1'b1;
          cmd.kind         = K_VALUE;
          cmd.item_length  = pending_length;
          cmd.value_byte   = data_byte;
          cmd.value_offset = value_count;
          value_count_next = count_inc;
          if (count_inc == pending_length) begin
            if (after == 8'd0) begin
              cmd.with_end = 1'b1;
              phase_next   = PH_IDLE;
            end else begin
              phase_next = PH_TYPE;
            end
          end else if (after == 8'd0) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          if (after == 8'd0) begin
            phase_next = PH_IDLE;
          end
        end
      endcase

      if (do_finish) begin
        emit = 1'b1;
        if (after < {1'b0, fin_len}) begin
          cmd.kind   = K_ERROR;
          phase_next = (after == 8'd0) ? PH_IDLE : PH_DROP;
        end else begin
          cmd.kind         = K_HEADER;
          cmd.item_type    = fin_type;
          cmd.item_length  = fin_len;
          value_count_next = '0;
          if (fin_len != 7'd0) begin
            phase_next = PH_VALUE;
          end else if (after == 8'd0) begin
            cmd.with_end = 1'b1;
            phase_next   = PH_IDLE;
          end else begin
            phase_next = PH_TYPE;
          end
        end
      end

      if (phase_next == PH_LEN && after == 8'd0) begin
        phase_next = PH_IDLE;
      end
    end
  end

  assign push     = accept && emit;
  assign push_cmd = cmd;

endmodule

>>> rtl/tlv_queue.sv
// ----------------------------------------------------------------------------
// TLV decoder command queue
// Short FIFO that decouples the parse front end from the result back end.
// ----------------------------------------------------------------------------
`include "tlv_stream_decoder_assert.svh"

module tlv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tlv_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tlv_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);
  import tlv_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_cmd = entries[rd_ptr];
  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);

  `TLV_ASSERT_ALWAYS(a_no_push_when_full, !(push && full))
  `TLV_ASSERT_ALWAYS(a_no_pop_when_empty, !(pop && empty))
  `TLV_ASSERT_NEXT(a_count_grows, push && !pop, count == $past(count) + 1'b1)

endmodule

>>> rtl/tlv_back.sv
// ----------------------------------------------------------------------------
// TLV decoder back end
// Expands queued commands into result transfers, one per cycle while the
// receiver does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
`include "tlv_stream_decoder_assert.svh"

module tlv_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  tlv_pkg::cmd_t pop_cmd,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [1:0]    result_kind,
  output logic [15:0]   item_type,
  output logic [6:0]    item_length,
  output logic [7:0]    value_byte,
  output logic [6:0]    value_offset,
  output logic          last_of_run
);
  import tlv_pkg::*;

  logic pending_end;
  logic out_free;

  assign out_free = !result_valid || !result_stall;
  assign pop      = out_free && !pending_end && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pending_end  <= 1'b0;
    end else if (out_free) begin
      if (pending_end) begin
        result_valid <= 1'b1;
        pending_end  <= 1'b0;
      end else begin
        result_valid <= !empty;
        pending_end  <= !empty && pop_cmd.with_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pending_end) begin
        result_kind  <= K_END;
        item_type    <= '0;
        item_length  <= '0;
        value_byte   <= '0;
        value_offset <= '0;
        last_of_run  <= 1'b1;
      end else begin
        result_kind  <= pop_cmd.kind;
        item_type    <= pop_cmd.item_type;
        item_length  <= pop_cmd.item_length;
        value_byte   <= pop_cmd.value_byte;
        value_offset <= pop_cmd.value_offset;
        last_of_run  <= !pop_cmd.with_end;
      end
    end
  end

  `TLV_ASSERT_ALWAYS(a_end_follows_shown, !pending_end || (result_valid &&
      (result_kind == K_HEADER || result_kind == K_VALUE) && !last_of_run))

endmodule

>>> rtl/tlv_stream_decoder.sv
// ----------------------------------------------------------------------------
// TLV stream decoder
// Byte channel in: data_byte, buffer_start, buffer_length with byte_valid and
// byte_stall. A transfer happens at a clock edge with valid high, stall low.
// Result channel out: result_kind, item_type, item_length, value_byte,
// value_offset, last_of_run with result_valid and result_stall.
// Each byte is classified by the front end in the cycle it is taken; bytes
// that cause results place one command in a four-entry queue, and the back
// end expands it into one or two result transfers, one per cycle while result_stall is low.
// A result goes from its byte transfer through a queue entry and then the
// output register. Bytes are taken one per cycle while byte_stall is low; a
// byte causing a header or value plus an end marker yields two results.
// A result stalled by the receiver holds; the queue absorbs bytes until it
// fills, then byte_stall rises.
// Reset clears the parse state, the queue and the output valid; no results
// are pending after reset and the block waits for a buffer start.
// ----------------------------------------------------------------------------
module tlv_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_start,
  input  logic [7:0]  buffer_length,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [15:0] item_type,
  output logic [6:0]  item_length,
  output logic [7:0]  value_byte,
  output logic [6:0]  value_offset,
  output logic        last_of_run
);
  import tlv_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  tlv_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .buffer_start  (buffer_start),
    .buffer_length (buffer_length),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  tlv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  tlv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_cmd      (pop_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .item_type    (item_type),
    .item_length  (item_length),
    .value_byte   (value_byte),
    .value_offset (value_offset),
    .last_of_run  (last_of_run)
  );

endmodule
